/* rtl/round_robin_group_fifo_scheduler_assert.svh */
// Assertion macros for the round-robin group scheduler.
`ifndef ROUND_ROBIN_GROUP_FIFO_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_GROUP_FIFO_SCHEDULER_ASSERT_SVH

// cond must never hold outside reset
`define RRGFS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define RRGFS_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/rrgfs_pkg.sv */
// Shared types and codes for the round-robin group scheduler.
package rrgfs_pkg;

  typedef enum logic [1:0] {
    OP_ADD_GROUP  = 2'd0,
    OP_ADD_MEMBER = 2'd1,
    OP_SERVE      = 2'd2,
    OP_NOP        = 2'd3
  } op_t;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_EMPTY         = 3'd1;
  localparam logic [2:0] ST_GROUP_EXISTS  = 3'd2;
  localparam logic [2:0] ST_GROUP_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_MEMBER_EXISTS = 3'd4;
  localparam logic [2:0] ST_FIFO_FULL     = 3'd5;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_FETCH,
    BK_EXEC
  } bk_state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] group_id;
    logic [7:0] member_id;
  } rrgfs_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] served_group;
    logic [7:0] served_member;
    logic       member_valid;
    logic       group_requeued;
    logic [4:0] groups_pending;
  } rrgfs_out_t;

  typedef struct packed {
    op_t        op;
    logic       gid_ok;
    logic [3:0] group_id;
    logic [7:0] member_id;
  } rrgfs_cmd_t;

endpackage

/* rtl/rrgfs_fifo.sv */
// Two-entry queue used between the scheduler stages.
module rrgfs_fifo #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  T     wr_data,
  output logic full,
  input  logic rd_en,
  output T     rd_data,
  output logic empty
);

  T           mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wptr_nxt = do_wr ? ~wptr_r : wptr_r;
    rptr_nxt = do_rd ? ~rptr_r : rptr_r;
    cnt_nxt  = 2'(cnt_r + {1'b0, do_wr} - {1'b0, do_rd});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/rrgfs_front.sv */
// Front stage: accepts commands, decodes them and queues them for the back stage.
module rrgfs_front import rrgfs_pkg::*; #(
  parameter int MAX_GROUPS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  rrgfs_in_t  in_data,
  input  logic       cmd_pop,
  output logic       cmd_empty,
  output rrgfs_cmd_t cmd_out
);

  rrgfs_cmd_t dec;

  always_comb begin
    dec.op        = op_t'(in_data.cmd);
    dec.gid_ok    = (int'(in_data.group_id) < MAX_GROUPS);
    dec.group_id  = in_data.group_id;
    dec.member_id = in_data.member_id;
  end

  rrgfs_fifo #(.T(rrgfs_cmd_t)) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (dec),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

endmodule

/* rtl/rrgfs_back.sv */
// Back stage: executes commands against the order ring and member queues.
module rrgfs_back import rrgfs_pkg::*; #(
  parameter int MAX_GROUPS        = 16,
  parameter int MEMBERS_PER_GROUP = 16,
  parameter int MEMBER_ID_SPACE   = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  rrgfs_cmd_t cmd_in,
  input  logic       cmd_empty,
  output logic       cmd_pop,
  input  logic       res_full,
  output logic       res_push,
  output rrgfs_out_t res
);

  localparam int GW  = $clog2(MAX_GROUPS);
  localparam int CW  = $clog2(MAX_GROUPS + 1);
  localparam int HW  = $clog2(MEMBERS_PER_GROUP);
  localparam int MCW = $clog2(MEMBERS_PER_GROUP + 1);
  localparam int SD  = MAX_GROUPS * MEMBERS_PER_GROUP;
  localparam int SAW = $clog2(SD);
  localparam int PD  = MAX_GROUPS * MEMBER_ID_SPACE;
  localparam int PAW = $clog2(PD);

  bk_state_t  state_r, state_nxt;
  rrgfs_cmd_t cur_r;
  logic [GW-1:0]  h_r;
  logic [PAW-1:0] clr_r, clr_nxt;

  logic [GW-1:0]  ring_r   [MAX_GROUPS];
  logic           active_r [MAX_GROUPS];
  logic [HW-1:0]  mhead_r  [MAX_GROUPS];
  logic [MCW-1:0] mcount_r [MAX_GROUPS];
  logic [GW-1:0]  ohead_r, ohead_nxt;
  logic [CW-1:0]  ocount_r, ocount_nxt;

  logic [7:0] store_mem [SD];
  logic       pres_mem  [PD];
  logic [7:0] store_q_r;
  logic       pres_q_r;

  logic fetch_go, exec_go;

  // fetch addresses
  logic [GW-1:0]  gi_in, h_in;
  logic [SAW-1:0] store_raddr;
  logic [PAW-1:0] pres_raddr;

  // execute controls
  logic [GW-1:0]  gi, idx, tail;
  logic [GW:0]    tail_sum;
  logic [HW:0]    slot_sum, hinc_sum;
  logic [HW-1:0]  slot;
  logic [MCW-1:0] mc_cur;
  logic           ring_we, act_we, act_wd, mc_we, mh_we, st_we, pr_we, pr_wd;
  logic [GW-1:0]  ring_wd;
  logic [MCW-1:0] mc_wd;
  logic [HW-1:0]  mh_wd;
  logic [SAW-1:0] st_wa;
  logic [PAW-1:0] pr_wa;
  logic [7:0]     st_wd;

  // state machine
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: if (clr_r == PAW'(PD - 1)) state_nxt = BK_FETCH;
      BK_FETCH: if (!cmd_empty && !res_full) state_nxt = BK_EXEC;
      BK_EXEC:  state_nxt = BK_FETCH;
      default:  state_nxt = BK_CLEAR;
    endcase
  end

  always_comb begin
    fetch_go = 1'b0;
    exec_go  = 1'b0;
    clr_nxt  = clr_r;
    case (state_r)
      BK_CLEAR: clr_nxt = PAW'(clr_r + 1'b1);
      BK_FETCH: fetch_go = !cmd_empty && !res_full;
      BK_EXEC:  exec_go = 1'b1;
      default: begin
        fetch_go = 1'b0;
      end
    endcase
  end

  assign cmd_pop  = fetch_go;
  assign res_push = exec_go;

  always_comb begin
    gi_in       = GW'(cmd_in.group_id);
    h_in        = ring_r[ohead_r];
    store_raddr = SAW'(SAW'(h_in) * SAW'(MEMBERS_PER_GROUP) + SAW'(mhead_r[h_in]));
    pres_raddr  = PAW'(PAW'(gi_in) * PAW'(MEMBER_ID_SPACE) + PAW'(cmd_in.member_id));
  end

  // execute
  always_comb begin
    gi       = GW'(cur_r.group_id);
    tail_sum = (GW + 1)'(ohead_r) + (GW + 1)'(ocount_r);
    tail     = (tail_sum >= (GW + 1)'(MAX_GROUPS)) ?
               GW'(tail_sum - (GW + 1)'(MAX_GROUPS)) : GW'(tail_sum);
    idx      = (cur_r.op == OP_SERVE) ? h_r : gi;
    mc_cur   = mcount_r[idx];
    slot_sum = (HW + 1)'(mhead_r[idx]) + (HW + 1)'(mc_cur);
    slot     = (slot_sum >= (HW + 1)'(MEMBERS_PER_GROUP)) ?
               HW'(slot_sum - (HW + 1)'(MEMBERS_PER_GROUP)) : HW'(slot_sum);
    hinc_sum = (HW + 1)'(mhead_r[idx]) + (HW + 1)'(1);

    ring_we = 1'b0; ring_wd = gi;
    act_we  = 1'b0; act_wd  = 1'b0;
    mc_we   = 1'b0; mc_wd   = mc_cur;
    mh_we   = 1'b0; mh_wd   = '0;
    st_we   = 1'b0; st_wd   = cur_r.member_id;
    st_wa   = SAW'(SAW'(gi) * SAW'(MEMBERS_PER_GROUP) + SAW'(slot));
    pr_we   = 1'b0; pr_wd   = 1'b1;
    pr_wa   = PAW'(PAW'(gi) * PAW'(MEMBER_ID_SPACE) + PAW'(cur_r.member_id));
    ohead_nxt  = ohead_r;
    ocount_nxt = ocount_r;
    res = '0;

    case (cur_r.op)
      OP_ADD_GROUP: begin
        if (!cur_r.gid_ok) begin
          res.status = ST_GROUP_UNKNOWN;
        end else if (active_r[gi]) begin
          res.status = ST_GROUP_EXISTS;
        end else begin
          act_we     = 1'b1;
          act_wd     = 1'b1;
          ring_we    = 1'b1;
          ocount_nxt = CW'(ocount_r + 1'b1);
        end
      end
      OP_ADD_MEMBER: begin
        if (!cur_r.gid_ok || !active_r[gi]) begin
          res.status = ST_GROUP_UNKNOWN;
        end else if (int'(cur_r.member_id) >= MEMBER_ID_SPACE) begin
          res.status = ST_FIFO_FULL;
        end else if (pres_q_r) begin
          res.status = ST_MEMBER_EXISTS;
        end else if (mc_cur == MCW'(MEMBERS_PER_GROUP)) begin
          res.status = ST_FIFO_FULL;
        end else begin
          st_we = 1'b1;
          pr_we = 1'b1;
          mc_we = 1'b1;
          mc_wd = MCW'(mc_cur + 1'b1);
        end
      end
      OP_SERVE: begin
        if (ocount_r == '0) begin
          res.status = ST_EMPTY;
        end else begin
          ohead_nxt = (ohead_r == GW'(MAX_GROUPS - 1)) ? '0 : GW'(ohead_r + 1'b1);
          res.served_group = 4'(h_r);
          if (mc_cur != '0) begin
            res.served_member = store_q_r;
            res.member_valid  = 1'b1;
            pr_we = 1'b1;
            pr_wd = 1'b0;
            pr_wa = PAW'(PAW'(h_r) * PAW'(MEMBER_ID_SPACE) + PAW'(store_q_r));
            mc_we = 1'b1;
            mc_wd = MCW'(mc_cur - 1'b1);
            mh_we = 1'b1;
            mh_wd = (hinc_sum >= (HW + 1)'(MEMBERS_PER_GROUP)) ? '0 : HW'(hinc_sum);
          end
          if (mc_cur > MCW'(1)) begin
            res.group_requeued = 1'b1;
            ring_we = 1'b1;
            ring_wd = h_r;
          end else begin
            ocount_nxt = CW'(ocount_r - 1'b1);
            act_we = 1'b1;
            act_wd = 1'b0;
            mh_we  = 1'b1;
            mh_wd  = '0;
          end
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    res.groups_pending = 5'(ocount_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_CLEAR;
      clr_r    <= '0;
      ohead_r  <= '0;
      ocount_r <= '0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        active_r[i] <= 1'b0;
        mhead_r[i]  <= '0;
        mcount_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (exec_go) begin
        ohead_r  <= ohead_nxt;
        ocount_r <= ocount_nxt;
        if (act_we) active_r[idx] <= act_wd;
        if (mc_we)  mcount_r[idx] <= mc_wd;
        if (mh_we)  mhead_r[idx]  <= mh_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_go) begin
      cur_r <= cmd_in;
      h_r   <= h_in;
    end
    if (exec_go && ring_we) begin
      ring_r[tail] <= ring_wd;
    end
  end

  // member store
  always_ff @(posedge clk) begin
    if (exec_go && st_we) begin
      store_mem[st_wa] <= st_wd;
    end
    if (fetch_go) begin
      store_q_r <= store_mem[store_raddr];
    end
  end

  // presence bitmap
  always_ff @(posedge clk) begin
    if (state_r == BK_CLEAR) begin
      pres_mem[clr_r] <= 1'b0;
    end else if (exec_go && pr_we) begin
      pres_mem[pr_wa] <= pr_wd;
    end
    if (fetch_go) begin
      pres_q_r <= pres_mem[pres_raddr];
    end
  end

endmodule

/* rtl/round_robin_group_fifo_scheduler.sv */
// Top level of the two-level round-robin group scheduler.
// Usage:
//   Commands enter as queue writes: in_data is taken when push is high and
//   full is low. Results leave as queue reads: out_data is valid while empty
//   is low and is taken when pop is high.
//   Every command gives exactly one result, in command order.
// Flow:
//   A command waits in the input queue until the executor is in its fetch
//   state with room in the result queue; the fetch pops it and registers the
//   member memory reads, then the execute state pushes its result. No new
//   command is fetched while one executes, for the member read-modify-write.
// Reset:
//   After rst_n the executor clears the presence bitmap, one entry a cycle,
//   all MAX_GROUPS * MEMBER_ID_SPACE entries (4096 by default). Commands
//   are queued meanwhile (two deep) and run once the pass ends.
// Stalls:
//   If pop stays low the result queue fills (two deep), the executor waits,
//   then the input queue fills and full rises. Nothing is dropped.
module round_robin_group_fifo_scheduler import rrgfs_pkg::*; #(
  parameter int MAX_GROUPS        = 16,
  parameter int MEMBERS_PER_GROUP = 16,
  parameter int MEMBER_ID_SPACE   = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  rrgfs_in_t  in_data,
  output logic       empty,
  input  logic       pop,
  output rrgfs_out_t out_data
);

  rrgfs_cmd_t cmd;
  rrgfs_out_t res;
  logic       cmd_empty, cmd_pop, res_full, res_push;

  rrgfs_front #(.MAX_GROUPS(MAX_GROUPS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd_out   (cmd)
  );

  rrgfs_back #(
    .MAX_GROUPS        (MAX_GROUPS),
    .MEMBERS_PER_GROUP (MEMBERS_PER_GROUP),
    .MEMBER_ID_SPACE   (MEMBER_ID_SPACE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_in    (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  rrgfs_fifo #(.T(rrgfs_out_t)) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_data),
    .empty   (empty)
  );

`include "round_robin_group_fifo_scheduler_assert.svh"

  `RRGFS_NEVER(a_no_push_when_full, res_push && res_full, "result pushed into full queue")
  `RRGFS_IMPLY(a_pend_max, !empty, int'(out_data.groups_pending) <= MAX_GROUPS, "pending high")
  `RRGFS_IMPLY(a_rq_mv, !empty && out_data.group_requeued, out_data.member_valid, "bad requeue")
  `RRGFS_IMPLY(a_mv_ok, !empty && out_data.member_valid, out_data.status == ST_OK, "bad status")

endmodule
